// ===== hdl/ncs_pkg.sv =====
// Shared types and constants for the nearest centroid search block.
`default_nettype none
package ncs_pkg;

    // Distance sum width and the width shown on the result port.
    localparam int SUM_W  = 39;
    localparam int DIST_W = 38;
    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // Operation codes of an input item.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register select bit of the configuration address.
    localparam logic REG_ACTIVE_MEANS = 1'b0;
    localparam logic REG_ACTIVE_DIMS  = 1'b1;

    localparam logic [4:0] ACTIVE_MEANS_RST = 5'd16;
    localparam logic [6:0] ACTIVE_DIMS_RST  = 7'd64;

    // Controls broadcast from the sequencer to every distance cell.
    typedef struct packed {
        logic clear;
        logic load;
        logic read;
        logic square;
        logic accumulate;
        logic flush;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== hdl/ncs_cell.sv =====
// One distance cell: a centroid row, its running squared distance and a link of the min chain.
`default_nettype none
module ncs_cell
    import ncs_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int SB        = 16,
    parameter int DIMENSION = 64,
    parameter int IW        = 4,
    parameter int AW        = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [3:0]            i_mean_index,
    input  wire logic [AW-1:0]         i_addr,
    input  wire logic signed [SB-1:0]  i_wdata,
    input  wire logic signed [SB-1:0]  i_query,
    input  wire logic [4:0]            i_active_means,
    input  wire logic [IW-1:0]         i_best_idx,
    input  wire logic [SUM_W-1:0]      i_best_sum,
    output logic [IW-1:0]              o_best_idx,
    output logic [SUM_W-1:0]           o_best_sum
);

    logic signed [SB-1:0]  r_mem [DIMENSION];
    logic signed [SB-1:0]  r_rdata;
    logic [2*SB+1:0]       r_sq;
    logic [SUM_W-1:0]      r_sum;
    logic [SUM_W-1:0]      n_sum;
    logic [IW-1:0]         r_best_idx;
    logic [SUM_W-1:0]      r_best_sum;
    logic signed [SB:0]    diff;
    logic [SB:0]           mag;
    logic                  sel;
    logic                  act;
    logic                  we;

    assign sel = (32'(i_mean_index) == IDX);
    assign act = (IDX == 0) || (32'(i_active_means) > IDX);
    assign we  = i_ctl.clear || (i_ctl.load && sel);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.read) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign diff = $signed({i_query[SB-1], i_query}) - $signed({r_rdata[SB-1], r_rdata});
    assign mag  = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);

    always_ff @(posedge i_clk) begin
        if (i_ctl.square) begin
            r_sq <= (2*SB+2)'(mag) * (2*SB+2)'(mag);
        end
    end

    // Sums wrap modulo the sum width.
    always_comb begin
        n_sum = r_sum;
        if (i_ctl.flush) begin
            n_sum = '0;
        end else if (i_ctl.accumulate) begin
            n_sum = r_sum + SUM_W'(r_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // Strict compare keeps the lower index on a tie.
    always_ff @(posedge i_clk) begin
        if (act && (r_sum < i_best_sum)) begin
            r_best_idx <= IW'(IDX);
            r_best_sum <= r_sum;
        end else begin
            r_best_idx <= i_best_idx;
            r_best_sum <= i_best_sum;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best_sum = r_best_sum;

endmodule
`default_nettype wire

// ===== hdl/nearest_centroid_search.sv =====
// Top level: sequencer, configuration registers and the chain of distance cells.
// Load item: busy stays low. Query element: row read, square, add; busy is high for square and add.
// Last query element: after the add the min walks the chain in S_SCAN, then S_DONE raises o_valid.
// o_valid is a one-cycle strobe; the receiver cannot stall, so results are never held.
// After reset a clearing pass zeroes every address of the centroid table with busy high.
// Sums and element count are cleared by reset, registers take their reset values; register writes work during clear.
`default_nettype none
module nearest_centroid_search
    import ncs_pkg::*;
#(
    parameter int NUM_MEANS   = 16,
    parameter int DIMENSION   = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_operation,
    input  wire logic [3:0]         i_mean_index,
    input  wire logic [5:0]         i_element_index,
    input  wire logic signed [15:0] i_value,
    input  wire logic               i_last,
    output logic                    o_valid,
    output logic [3:0]              o_closest_index,
    output logic [DIST_W-1:0]       o_nearest_sqdist,
    output logic                    o_length_error,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int SB = SAMPLE_BITS;
    localparam int IW = (NUM_MEANS > 1) ? $clog2(NUM_MEANS) : 1;
    localparam int AW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SQ,
        S_ACC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_clr;
    logic [IW-1:0]        r_scan;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_in_range;
    logic                 r_last;
    logic                 r_err;
    logic signed [SB-1:0] r_query;
    logic                 r_valid;
    logic [3:0]           r_closest;
    logic [DIST_W-1:0]    r_min;
    logic [4:0]           r_active_means;
    logic [6:0]           r_active_dims;

    logic                 accept;
    logic                 in_range;
    logic                 length_bad;
    logic                 cfg_wr;
    logic signed [SB-1:0] sample;
    logic [AW-1:0]        addr;
    logic signed [SB-1:0] wdata;
    t_cell_ctl            ctl;

    logic [IW-1:0]        w_idx [NUM_MEANS+1];
    logic [SUM_W-1:0]     w_sum [NUM_MEANS+1];

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign sample = $signed(SB'($unsigned(i_value)));

    assign in_range   = (r_count < r_active_dims) && (32'(r_count) < DIMENSION);
    assign length_bad = ((8'(r_count) + 8'd1) != 8'(r_active_dims))
                     || (32'(r_active_dims) > DIMENSION);

    always_comb begin
        ctl            = '0;
        ctl.clear      = (r_state == S_CLEAR);
        ctl.load       = accept && (i_operation == OP_LOAD)
                      && (32'(i_mean_index) < NUM_MEANS)
                      && (32'(i_element_index) < DIMENSION);
        ctl.read       = accept && (i_operation == OP_QUERY) && in_range;
        ctl.square     = (r_state == S_SQ);
        ctl.accumulate = (r_state == S_ACC) && r_in_range;
        ctl.flush      = (r_state == S_DONE);
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            addr  = r_clr;
            wdata = '0;
        end else if (i_operation == OP_LOAD) begin
            addr  = AW'(i_element_index);
            wdata = sample;
        end else begin
            addr  = AW'(r_count);
            wdata = sample;
        end
    end

    // Seed the chain with the largest sum so cell 0 always sets the start value.
    assign w_idx[0] = '0;
    assign w_sum[0] = '1;

    for (genvar m = 0; m < NUM_MEANS; m++) begin : g_cell
        ncs_cell #(
            .IDX       (m),
            .SB        (SB),
            .DIMENSION (DIMENSION),
            .IW        (IW),
            .AW        (AW)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_mean_index   (i_mean_index),
            .i_addr         (addr),
            .i_wdata        (wdata),
            .i_query        (r_query),
            .i_active_means (r_active_means),
            .i_best_idx     (w_idx[m]),
            .i_best_sum     (w_sum[m]),
            .o_best_idx     (w_idx[m+1]),
            .o_best_sum     (w_sum[m+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_scan  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DIMENSION - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && (i_operation == OP_QUERY)) begin
                        r_query    <= sample;
                        r_in_range <= in_range;
                        r_last     <= i_last;
                        r_err      <= length_bad;
                        if (i_last) begin
                            r_count <= '0;
                        end else if (r_count != COUNT_MAX) begin
                            r_count <= r_count + COUNT_W'(1);
                        end
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_scan  <= '0;
                    r_state <= r_last ? S_SCAN : S_IDLE;
                end
                S_SCAN: begin
                    // Let the minimum ripple through every cell.
                    r_scan <= r_scan + IW'(1);
                    if (r_scan == IW'(NUM_MEANS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid   <= 1'b1;
                    r_closest <= 4'(w_idx[NUM_MEANS]);
                    r_min     <= w_sum[NUM_MEANS][DIST_W-1:0];
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_means <= ACTIVE_MEANS_RST;
            r_active_dims  <= ACTIVE_DIMS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ACTIVE_MEANS) begin
                r_active_means <= pwdata[4:0];
            end else begin
                r_active_dims <= pwdata[6:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_DIMS) ? 32'(r_active_dims) : 32'(r_active_means);

    assign o_valid          = r_valid;
    assign o_closest_index  = r_closest;
    assign o_nearest_sqdist = r_min;
    assign o_length_error   = r_err;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block not busy while clearing the centroid table");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done step");

    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == OP_QUERY) && i_last) |-> ##(NUM_MEANS + 4) o_valid)
        else $error("last query element gave no result in time");

    a_chain_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (32'(w_idx[NUM_MEANS]) < NUM_MEANS))
        else $error("chain produced an index beyond the centroid count");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for nearest_centroid_search: directed table, then randomized phases.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ncs_pkg::*;

    localparam int MEANS         = 16;
    localparam int DIMS          = 64;
    localparam int ITEM_TARGET   = 800;
    localparam int MIN_RESULTS   = 48;
    localparam int PHASE_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 2 * MEANS + 16;
    localparam int LONG_QUERY    = 130;

    typedef struct packed {
        logic               op;
        logic [3:0]         mean;
        logic [5:0]         elem;
        logic signed [15:0] value;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [3:0]        idx;
        logic [DIST_W-1:0] sqdist;
        logic              err;
    } t_nearest;

    typedef struct packed {
        t_item    item;
        logic     typed;
        t_nearest want;
    } t_row;

    localparam t_nearest NO_WANT = '0;

    // Run with active_means = 16, active_dims = 4.
    localparam int DIR_N = 21;
    localparam t_row DIR_ROWS [DIR_N] = '{
        // zero table: every centroid ties, lowest index wins
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh8000, 1'b1}, 1'b1, '{4'd0, 38'd1073741824, 1'b1}},
        '{'{OP_QUERY, 4'hF, 6'h3F, 16'sh7FFF, 1'b1}, 1'b1, '{4'd0, 38'd1073676289, 1'b1}},
        '{'{OP_LOAD,  4'hF, 6'h00, 16'sh8000, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_LOAD,  4'h3, 6'h00, 16'sh7FFF, 1'b1}, 1'b0, NO_WANT},
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh8000, 1'b1}, 1'b1, '{4'd15, 38'd0, 1'b1}},
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh7FFF, 1'b1}, 1'b1, '{4'd3, 38'd0, 1'b1}},
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh0000, 1'b1}, 1'b1, '{4'd0, 38'd0, 1'b1}},
        '{'{OP_LOAD,  4'h0, 6'h3F, 16'sh7FFF, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_LOAD,  4'hF, 6'h3F, 16'sh8000, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_LOAD,  4'h7, 6'h01, 16'sh5555, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_LOAD,  4'h7, 6'h02, 16'shAAAA, 1'b0}, 1'b0, NO_WANT},
        // full-length query
        '{'{OP_QUERY, 4'hA, 6'h15, 16'sh5555, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_QUERY, 4'h5, 6'h2A, 16'shAAAA, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_QUERY, 4'h0, 6'h00, 16'shFFFF, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_QUERY, 4'hF, 6'h3F, 16'sh7FFF, 1'b1}, 1'b0, NO_WANT},
        // one element too many, with a load in the middle
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh0001, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_LOAD,  4'h1, 6'h02, 16'sh0001, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh8000, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh0002, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh0003, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_QUERY, 4'h0, 6'h00, 16'sh0004, 1'b1}, 1'b0, NO_WANT}
    };

    localparam int PHASE_N = 13;
    localparam int PH_MEANS [PHASE_N] = '{16, 1, 16, 0, 31, 5, 17, 8, 4, 12, 2, 16, 16};
    localparam int PH_DIMS  [PHASE_N] = '{64, 1, 2, 3, 5, 8, 4, 0, 127, 100, 64, 16, 6};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_operation = 1'b0;
    logic [3:0]         i_mean_index = '0;
    logic [5:0]         i_element_index = '0;
    logic signed [15:0] i_value = '0;
    logic               i_last = 1'b0;
    logic               o_valid;
    logic [3:0]         o_closest_index;
    logic [DIST_W-1:0]  o_nearest_sqdist;
    logic               o_length_error;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state
    logic signed [15:0] cent_mem [MEANS][DIMS];
    logic [SUM_W-1:0]   dist_acc [MEANS];
    logic [COUNT_W-1:0] elems_seen;
    logic [4:0]         cfg_means;
    logic [6:0]         cfg_dims;

    t_nearest nearest_due [$];

    int  items_sent   = 0;
    int  loads_sent   = 0;
    int  queries_done = 0;
    int  err_due      = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  mismatches   = 0;
    bit  idling       = 1'b1;
    bit  long_due     = 1'b0;
    int  cur_dims     = 0;

    nearest_centroid_search dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_mean_index     (i_mean_index),
        .i_element_index  (i_element_index),
        .i_value          (i_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .o_closest_index  (o_closest_index),
        .o_nearest_sqdist (o_nearest_sqdist),
        .o_length_error   (o_length_error),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #2 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // Apply one item to the shadow state; returns 1 when the item closes a query.
    function automatic bit search_step(input t_item it, output t_nearest res);
        int unsigned      pos;
        int unsigned      len;
        int unsigned      n_act;
        int unsigned      best_i;
        longint           d;
        logic [SUM_W-1:0] best;
        res = '0;
        if (it.op == OP_LOAD) begin
            cent_mem[it.mean][it.elem] = it.value;
            return 1'b0;
        end
        pos = elems_seen;
        if (pos < cfg_dims && pos < DIMS) begin
            for (int m = 0; m < MEANS; m++) begin
                d = longint'(it.value) - longint'(cent_mem[m][pos]);
                dist_acc[m] = dist_acc[m] + SUM_W'(d * d);
            end
        end
        if (!it.last) begin
            if (elems_seen != COUNT_MAX)
                elems_seen = elems_seen + 1'b1;
            return 1'b0;
        end
        len = pos + 1;
        n_act = (cfg_means == 0) ? 1 : ((cfg_means > MEANS) ? MEANS : cfg_means);
        best_i = 0;
        best = dist_acc[0];
        for (int m = 1; m < n_act; m++) begin
            if (dist_acc[m] < best) begin
                best = dist_acc[m];
                best_i = m;
            end
        end
        res.idx = 4'(best_i);
        res.sqdist = best[DIST_W-1:0];
        res.err = (len != cfg_dims) || (cfg_dims > DIMS);
        for (int m = 0; m < MEANS; m++)
            dist_acc[m] = '0;
        elems_seen = '0;
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] sample_value();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_item centroid_load();
        t_item it;
        it.op = OP_LOAD;
        it.mean = 4'($urandom);
        // mostly hit positions that the active dimensions actually use
        if (cur_dims > 0 && $urandom_range(0, 3) != 0)
            it.elem = 6'($urandom_range(0, (cur_dims > DIMS ? DIMS : cur_dims) - 1));
        else
            it.elem = 6'($urandom);
        it.value = ($urandom_range(0, 1) != 0) ? sample_value() : 16'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_nearest want);
        t_nearest pred;
        start <= 1'b1;
        i_operation <= it.op;
        i_mean_index <= it.mean;
        i_element_index <= it.elem;
        i_value <= it.value;
        i_last <= it.last;
        do @(posedge i_clk); while (busy);
        if (search_step(it, pred)) begin
            nearest_due.push_back(typed ? want : pred);
            queries_done++;
            if (pred.err)
                err_due++;
        end
        items_sent++;
        if (it.op == OP_LOAD)
            loads_sent++;
        if (idling && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic hold_items();
        if (start)
            start <= 1'b0;
    endtask

    task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                             output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input int unsigned value);
        logic [31:0] mask;
        logic [31:0] data;
        logic [31:0] rd;
        mask = (sel == REG_ACTIVE_DIMS) ? 32'h7F : 32'h1F;
        // random upper bits must not reach the register
        data = (value & mask) | ($urandom & ~mask);
        apb_cycle(1'b1, {sel, 2'b00}, data, rd);
        if (sel == REG_ACTIVE_DIMS)
            cfg_dims = data[6:0];
        else
            cfg_means = data[4:0];
        reg_writes++;
        apb_cycle(1'b0, {sel, 2'b00}, '0, rd);
        if (rd !== (data & mask))
            flag_mismatch($sformatf("register %0d reads %0h, wrote %0h", sel, rd, data & mask));
    endtask

    // Drain pending results, then let any query element in flight finish before touching registers.
    task automatic settle();
        hold_items();
        while (nearest_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_query_burst();
        t_item it;
        int    len;
        repeat ($urandom_range(0, 3)) send_item(centroid_load(), 1'b0, NO_WANT);
        if (long_due) begin
            len = LONG_QUERY;
            long_due = 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
            len = (cur_dims == 0) ? $urandom_range(1, 8) : cur_dims;
        end else if ($urandom_range(0, 2) != 0) begin
            len = $urandom_range(1, cur_dims + 2);
        end else begin
            len = (cur_dims > DIMS) ? $urandom_range(128, 131) : $urandom_range(1, 3);
        end
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0)
                send_item(centroid_load(), 1'b0, NO_WANT);
            it.op = OP_QUERY;
            it.mean = 4'($urandom);
            it.elem = 6'($urandom);
            it.value = sample_value();
            it.last = (k == len - 1);
            send_item(it, 1'b0, NO_WANT);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin : take_result
            t_nearest want;
            results_seen++;
            if (nearest_due.size() == 0) begin
                flag_mismatch("result strobe with no query pending");
            end else begin
                want = nearest_due.pop_front();
                if (o_closest_index !== want.idx)
                    flag_mismatch($sformatf("closest_index %0d, expected %0d",
                                            o_closest_index, want.idx));
                if (o_nearest_sqdist !== want.sqdist)
                    flag_mismatch($sformatf("nearest_sqdist %0d, expected %0d",
                                            o_nearest_sqdist, want.sqdist));
                if (o_length_error !== want.err)
                    flag_mismatch($sformatf("length_error %0b, expected %0b",
                                            o_length_error, want.err));
            end
        end
    end

    initial begin
        for (int m = 0; m < MEANS; m++) begin
            dist_acc[m] = '0;
            for (int e = 0; e < DIMS; e++)
                cent_mem[m][e] = '0;
        end
        elems_seen = '0;
        cfg_means = ACTIVE_MEANS_RST;
        cfg_dims = ACTIVE_DIMS_RST;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers take writes during the table clear; items wait on busy
        write_reg(REG_ACTIVE_MEANS, 16);
        write_reg(REG_ACTIVE_DIMS, 4);
        cur_dims = 4;
        for (int i = 0; i < DIR_N; i++)
            send_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        for (int p = 0; p < PHASE_N; p++) begin : phase
            int first;
            settle();
            write_reg(REG_ACTIVE_MEANS, PH_MEANS[p]);
            write_reg(REG_ACTIVE_DIMS, PH_DIMS[p]);
            cur_dims = PH_DIMS[p];
            long_due = (PH_DIMS[p] > DIMS);
            idling = (p % 3 != 2) && (p != PHASE_N - 1);
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS ||
                   (p == PHASE_N - 1 &&
                    (items_sent < ITEM_TARGET || queries_done < MIN_RESULTS)))
                send_query_burst();
        end

        settle();
        $display("Sent %0d items (%0d centroid loads) over %0d register writes;",
                 items_sent, loads_sent, reg_writes);
        $display("checked %0d nearest-centroid results, %0d of them with a length error.",
                 results_seen, err_due);
        if (mismatches == 0)
            $display("nearest_centroid_search: match");
        else
            $display("nearest_centroid_search: mismatch");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("nearest_centroid_search: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/ncs_pkg.sv
hdl/ncs_cell.sv
hdl/nearest_centroid_search.sv
test/testbench.sv
